/* src/tph_pkg.sv */
// Package for the three-point height sequencer: widths, phase and request
// codes, configuration indexes and the microcode ROM. No dependencies.
package tph_pkg;

  localparam int DIST_BITS = 16;
  localparam int FRAC_BITS = 4;
  localparam int CFG_W     = 16;
  localparam int PHASE_W   = 3;
  localparam int HEIGHT_W  = 20;
  localparam int TOTAL_W   = HEIGHT_W + 1;
  localparam int SQ_W      = 2 * DIST_BITS;
  localparam int RAD_W     = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int CNT_W     = $clog2(ROOT_W);
  localparam int CFG_IDX_W = 1;
  localparam int UPC_W     = 4;

  // Phase codes as seen on the result word.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HORIZ = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TOP   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BASE  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_RESET   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 1'b1;

  localparam logic [CFG_W-1:0] MIN_DIST_RST = 16'd10;
  localparam logic [CFG_W-1:0] MAX_DIST_RST = 16'd1200;

  localparam logic LEG_TOP  = 1'b0;
  localparam logic LEG_BASE = 1'b1;

  typedef enum logic [2:0] {
    OP_DISPATCH   = 3'd0,
    OP_SQ_H       = 3'd1,
    OP_SQ_LEG     = 3'd2,
    OP_ROOT_INIT  = 3'd3,
    OP_ROOT_STEP  = 3'd4,
    OP_STORE_TOP  = 3'd5,
    OP_STORE_BASE = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_LOOP     = 2'd1,
    JMP_HOME     = 2'd2,
    JMP_DISPATCH = 2'd3
  } jmp_e;

  typedef struct packed {
    op_e  op;
    logic leg;
    jmp_e jmp;
  } uword_t;

  // Microprogram addresses.
  localparam logic [UPC_W-1:0] S_DISPATCH   = 4'd0;
  localparam logic [UPC_W-1:0] S_SQ_H       = 4'd1;
  localparam logic [UPC_W-1:0] S_SQ_TOP     = 4'd2;
  localparam logic [UPC_W-1:0] S_INIT_TOP   = 4'd3;
  localparam logic [UPC_W-1:0] S_ROOT_TOP   = 4'd4;
  localparam logic [UPC_W-1:0] S_STORE_TOP  = 4'd5;
  localparam logic [UPC_W-1:0] S_SQ_BASE    = 4'd6;
  localparam logic [UPC_W-1:0] S_INIT_BASE  = 4'd7;
  localparam logic [UPC_W-1:0] S_ROOT_BASE  = 4'd8;
  localparam logic [UPC_W-1:0] S_STORE_BASE = 4'd9;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_DISPATCH, leg: LEG_TOP, jmp: JMP_HOME};
    case (addr)
      S_DISPATCH:   w = '{op: OP_DISPATCH,   leg: LEG_TOP,  jmp: JMP_DISPATCH};
      S_SQ_H:       w = '{op: OP_SQ_H,       leg: LEG_TOP,  jmp: JMP_NEXT};
      S_SQ_TOP:     w = '{op: OP_SQ_LEG,     leg: LEG_TOP,  jmp: JMP_NEXT};
      S_INIT_TOP:   w = '{op: OP_ROOT_INIT,  leg: LEG_TOP,  jmp: JMP_NEXT};
      S_ROOT_TOP:   w = '{op: OP_ROOT_STEP,  leg: LEG_TOP,  jmp: JMP_LOOP};
      S_STORE_TOP:  w = '{op: OP_STORE_TOP,  leg: LEG_TOP,  jmp: JMP_NEXT};
      S_SQ_BASE:    w = '{op: OP_SQ_LEG,     leg: LEG_BASE, jmp: JMP_NEXT};
      S_INIT_BASE:  w = '{op: OP_ROOT_INIT,  leg: LEG_BASE, jmp: JMP_NEXT};
      S_ROOT_BASE:  w = '{op: OP_ROOT_STEP,  leg: LEG_BASE, jmp: JMP_LOOP};
      S_STORE_BASE: w = '{op: OP_STORE_BASE, leg: LEG_BASE, jmp: JMP_HOME};
      default:      w = '{op: OP_DISPATCH,   leg: LEG_TOP,  jmp: JMP_HOME};
    endcase
    return w;
  endfunction

endpackage

/* src/three_point_height_sequencer.sv */
// Top level of the three-point height sequencer: event decode, microcoded
// height datapath and result register. Depends on tph_pkg.
//
//   Channel   Direction  Handshake                 Word
//   in        to block   in_valid_i / in_stall_o   req_type, distance_cm, reading_ok
//   out       from block out_valid_o / out_stall_i phase, heights, sum, flags
//   cfg       to block   cfg_valid_i / cfg_ready_o register index, 16-bit data
//
// Every event that does not complete a measurement gives its result word in
// the cycle after it is taken. The base capture runs the height program: one
// squaring, then per leg a squaring, a setup step, 20 restoring square-root
// steps (one root bit each) and a store. Reset clears the phase, the
// captured distances and the heights; the window registers return to 10
// and 1200 cm. While a result word waits under out_stall_i the block still
// takes the next word only when that result is being taken in the same cycle.
module three_point_height_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Event channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [tph_pkg::DIST_BITS-1:0]  distance_cm_i,
  input  logic                           reading_ok_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tph_pkg::PHASE_W-1:0]    phase_o,
  output logic [tph_pkg::HEIGHT_W-1:0]   top_height_o,
  output logic [tph_pkg::HEIGHT_W-1:0]   base_height_o,
  output logic [tph_pkg::TOTAL_W-1:0]    height_sum_o,
  output logic                           result_valid_o,
  output logic                           reading_rejected_o,
  // Configuration channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tph_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tph_pkg::CFG_W-1:0]      cfg_data_i
);
  import tph_pkg::*;

  // Window registers. The port can always take a write.
  logic [CFG_W-1:0] min_dist_q, max_dist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MIN_DIST_RST;
      max_dist_q <= MAX_DIST_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_DIST: min_dist_q <= cfg_data_i;
        CFG_MAX_DIST: max_dist_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state: microprogram counter plus the measurement state.
  logic [UPC_W-1:0]     upc_q, upc_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [DIST_BITS-1:0] horiz_q, horiz_d;
  logic [DIST_BITS-1:0] top_dist_q, top_dist_d;
  logic [HEIGHT_W-1:0]  top_h_q, top_h_d;
  logic [HEIGHT_W-1:0]  base_h_q, base_h_d;
  logic                 valid_q, valid_d;

  // Datapath registers, no reset needed.
  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic [SQ_W-1:0]      hsq_q, hsq_d;
  logic [SQ_W-1:0]      prod_q, prod_d;
  logic [RAD_W-1:0]     rad_q, rad_d;
  logic [ROOT_W:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [HEIGHT_W-1:0]  top_tmp_q, top_tmp_d;

  // Result register.
  logic                 out_valid_q;
  logic [PHASE_W-1:0]   out_phase_q;
  logic [HEIGHT_W-1:0]  out_top_q, out_base_q;
  logic [TOTAL_W-1:0]   out_total_q;
  logic                 out_rvalid_q, out_rej_q;

  uword_t               uw;
  logic                 in_fire, out_fire;
  logic                 in_window;
  logic                 load, rej, go_compute;
  logic [DIST_BITS-1:0] leg, mul_a;
  logic [SQ_W-1:0]      mul_p;
  logic [SQ_W-1:0]      diff;
  logic [ROOT_W+1:0]    rem_sh, trial;

  assign uw = ucode(upc_q);

  assign out_fire   = out_valid_q && !out_stall_i;
  // New events wait while the program runs or a result word is held.
  assign in_stall_o = (upc_q != S_DISPATCH) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign in_window = reading_ok_i && (distance_cm_i >= min_dist_q)
                     && (distance_cm_i <= max_dist_q);

  // One shared squarer; its product is registered before the subtract.
  assign leg   = (uw.leg == LEG_BASE) ? dist_q : top_dist_q;
  assign mul_a = (uw.op == OP_SQ_H) ? horiz_q : leg;
  assign mul_p = mul_a * mul_a;

  // Leg squared minus horizontal squared, or zero when the leg is not longer.
  assign diff = (leg > horiz_q) ? (prod_q - hsq_q) : '0;

  // Restoring square root, one result bit per step.
  assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    phase_d    = phase_q;
    horiz_d    = horiz_q;
    top_dist_d = top_dist_q;
    top_h_d    = top_h_q;
    base_h_d   = base_h_q;
    valid_d    = valid_q;
    dist_d     = dist_q;
    hsq_d      = hsq_q;
    prod_d     = prod_q;
    rad_d      = rad_q;
    rem_d      = rem_q;
    root_d     = root_q;
    cnt_d      = cnt_q;
    top_tmp_d  = top_tmp_q;
    load       = 1'b0;
    rej        = 1'b0;
    go_compute = 1'b0;

    case (uw.op)
      OP_DISPATCH: begin
        if (in_fire) begin
          load = 1'b1;
          if (req_type_i == REQ_RESET) begin
            phase_d    = PH_IDLE;
            horiz_d    = '0;
            top_dist_d = '0;
            top_h_d    = '0;
            base_h_d   = '0;
            valid_d    = 1'b0;
          end else begin
            case (phase_q)
              PH_IDLE: begin
                phase_d = PH_HORIZ;
              end
              PH_HORIZ: begin
                if (in_window) begin
                  horiz_d = distance_cm_i;
                  phase_d = PH_TOP;
                end else begin
                  rej = 1'b1;
                end
              end
              PH_TOP: begin
                if (in_window) begin
                  top_dist_d = distance_cm_i;
                  phase_d    = PH_BASE;
                end else begin
                  rej = 1'b1;
                end
              end
              PH_BASE: begin
                if (in_window) begin
                  // The result comes out of the height program instead.
                  dist_d     = distance_cm_i;
                  go_compute = 1'b1;
                  load       = 1'b0;
                end else begin
                  rej = 1'b1;
                end
              end
              default: begin
                // Complete, and any code past it, starts over.
                phase_d    = PH_IDLE;
                horiz_d    = '0;
                top_dist_d = '0;
                top_h_d    = '0;
                base_h_d   = '0;
                valid_d    = 1'b0;
              end
            endcase
          end
        end
      end
      OP_SQ_H: begin
        hsq_d = mul_p;
      end
      OP_SQ_LEG: begin
        prod_d = mul_p;
      end
      OP_ROOT_INIT: begin
        rad_d  = {diff, {(2 * FRAC_BITS){1'b0}}};
        rem_d  = '0;
        root_d = '0;
        cnt_d  = CNT_W'(ROOT_W - 1);
      end
      OP_ROOT_STEP: begin
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = (ROOT_W + 1)'(rem_sh - trial);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = (ROOT_W + 1)'(rem_sh);
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_STORE_TOP: begin
        top_tmp_d = HEIGHT_W'(root_q);
      end
      OP_STORE_BASE: begin
        top_h_d  = top_tmp_q;
        base_h_d = HEIGHT_W'(root_q);
        valid_d  = 1'b1;
        phase_d  = PH_DONE;
        load     = 1'b1;
      end
      default: ;
    endcase
  end

  // Next microprogram address.
  always_comb begin
    upc_d = upc_q;
    case (uw.jmp)
      JMP_NEXT:     upc_d = upc_q + 1'b1;
      JMP_LOOP:     upc_d = (cnt_q != '0) ? upc_q : upc_q + 1'b1;
      JMP_HOME:     upc_d = S_DISPATCH;
      JMP_DISPATCH: upc_d = go_compute ? S_SQ_H : S_DISPATCH;
      default:      upc_d = S_DISPATCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q      <= S_DISPATCH;
      phase_q    <= PH_IDLE;
      horiz_q    <= '0;
      top_dist_q <= '0;
      top_h_q    <= '0;
      base_h_q   <= '0;
      valid_q    <= 1'b0;
    end else begin
      upc_q      <= upc_d;
      phase_q    <= phase_d;
      horiz_q    <= horiz_d;
      top_dist_q <= top_dist_d;
      top_h_q    <= top_h_d;
      base_h_q   <= base_h_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q    <= dist_d;
    hsq_q     <= hsq_d;
    prod_q    <= prod_d;
    rad_q     <= rad_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    cnt_q     <= cnt_d;
    top_tmp_q <= top_tmp_d;
  end

  // Result register: loaded with the state as it stands after the event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_phase_q  <= phase_d;
      out_top_q    <= top_h_d;
      out_base_q   <= base_h_d;
      out_total_q  <= TOTAL_W'(top_h_d) + TOTAL_W'(base_h_d);
      out_rvalid_q <= valid_d;
      out_rej_q    <= rej;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign phase_o            = out_phase_q;
  assign top_height_o       = out_top_q;
  assign base_height_o      = out_base_q;
  assign height_sum_o       = out_total_q;
  assign result_valid_o     = out_rvalid_q;
  assign reading_rejected_o = out_rej_q;

  // Heights stay cleared until a measurement completes.
  a_heights_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_DONE) |-> (top_h_q == '0 && base_h_q == '0 && !valid_q))
    else $error("heights or valid set outside the complete phase");

  // The last program step always lands in complete with a valid result.
  a_store_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_STORE_BASE) |=> (phase_q == PH_DONE && valid_q && out_valid_q))
    else $error("height program ended without completing");

  // A rejection only happens in a capturing phase.
  a_rej_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rej_q) |->
      (out_phase_q == PH_HORIZ || out_phase_q == PH_TOP || out_phase_q == PH_BASE))
    else $error("rejection reported outside a capturing phase");

  // Events are only taken at the dispatch step.
  a_take_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (upc_q == S_DISPATCH && !(out_valid_q && out_stall_i)))
    else $error("event taken while the program runs or a result is held");

endmodule

/* tb/sv/three_point_height_sequencer_tb.sv */
// Self-checking testbench for the three-point height sequencer.
// It drives events and window settings, predicts every result word in a
// scoreboard class, and needs only tph_pkg and three_point_height_sequencer.
module three_point_height_sequencer_tb;
  import tph_pkg::*;

  // One result word as the block presents it on the output channel.
  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [HEIGHT_W-1:0] top_height;
    logic [HEIGHT_W-1:0] base_height;
    logic [TOTAL_W-1:0]  height_sum;
    logic                result_valid;
    logic                reading_rejected;
  } height_word_t;

  // The scoreboard keeps its own copy of the sequencer: the window, the
  // phase, the captured distances and the two heights. Every accepted event
  // advances that copy and leaves one expected word in the queue; every
  // word taken from the block is checked against the oldest one.
  class height_scoreboard;
    logic [CFG_W-1:0]     win_lo;
    logic [CFG_W-1:0]     win_hi;
    logic [PHASE_W-1:0]   phase;
    logic [DIST_BITS-1:0] horiz_cm;
    logic [DIST_BITS-1:0] top_cm;
    logic [HEIGHT_W-1:0]  top_h;
    logic [HEIGHT_W-1:0]  base_h;
    logic                 done;
    height_word_t         awaited_words[$];
    int unsigned          n_events;
    int unsigned          n_words;
    int unsigned          n_complete;
    int unsigned          n_refused;
    int unsigned          n_errors;

    function new();
      win_lo     = MIN_DIST_RST;
      win_hi     = MAX_DIST_RST;
      n_events   = 0;
      n_words    = 0;
      n_complete = 0;
      n_refused  = 0;
      n_errors   = 0;
      clear_measurement();
    endfunction

    function void clear_measurement();
      phase    = PH_IDLE;
      horiz_cm = '0;
      top_cm   = '0;
      top_h    = '0;
      base_h   = '0;
      done     = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_MIN_DIST) begin
        win_lo = value;
      end else begin
        win_hi = value;
      end
    endfunction

    // Height of one leg in 1/2^FRAC_BITS cm: the floor root of the scaled
    // difference of squares, found one result bit at a time from the top.
    function logic [HEIGHT_W-1:0] leg_rise(logic [DIST_BITS-1:0] slant,
                                           logic [DIST_BITS-1:0] level);
      logic [63:0] radicand;
      logic [63:0] root;
      logic [63:0] trial;
      if (slant <= level) return '0;
      radicand = (64'(slant) * slant - 64'(level) * level) << (2 * FRAC_BITS);
      root = '0;
      for (int b = HEIGHT_W + 3; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= radicand) root = trial;
      end
      if (root > 64'hFFFFF) return '1;
      return root[HEIGHT_W-1:0];
    endfunction

    function void note_event(logic req, logic [DIST_BITS-1:0] reading, logic ok);
      height_word_t w;
      logic         take;
      logic         refused;
      take    = ok && reading >= win_lo && reading <= win_hi;
      refused = 1'b0;
      n_events++;
      if (req == REQ_RESET) begin
        clear_measurement();
      end else begin
        case (phase)
          PH_IDLE: begin
            phase = PH_HORIZ;
          end
          PH_HORIZ: begin
            if (take) begin
              horiz_cm = reading;
              phase    = PH_TOP;
            end else begin
              refused = 1'b1;
            end
          end
          PH_TOP: begin
            if (take) begin
              top_cm = reading;
              phase  = PH_BASE;
            end else begin
              refused = 1'b1;
            end
          end
          PH_BASE: begin
            if (take) begin
              top_h  = leg_rise(top_cm, horiz_cm);
              base_h = leg_rise(reading, horiz_cm);
              done   = 1'b1;
              phase  = PH_DONE;
              n_complete++;
            end else begin
              refused = 1'b1;
            end
          end
          default: begin
            clear_measurement();
          end
        endcase
      end
      if (refused) n_refused++;
      w.phase            = phase;
      w.top_height       = top_h;
      w.base_height      = base_h;
      w.height_sum       = TOTAL_W'(top_h) + TOTAL_W'(base_h);
      w.result_valid     = done;
      w.reading_rejected = refused;
      awaited_words.push_back(w);
    endfunction

    function int backlog();
      return awaited_words.size();
    endfunction

    function void compare(string field, logic [TOTAL_W-1:0] want,
                          logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        n_errors++;
      end
    endfunction

    function void check_word(height_word_t got);
      height_word_t want;
      n_words++;
      if (awaited_words.size() == 0) begin
        $error("result word with no event waiting for it (phase %0d)", got.phase);
        n_errors++;
        return;
      end
      want = awaited_words.pop_front();
      compare("phase", want.phase, got.phase);
      compare("top_height", want.top_height, got.top_height);
      compare("base_height", want.base_height, got.base_height);
      compare("height_sum", want.height_sum, got.height_sum);
      compare("result_valid", want.result_valid, got.result_valid);
      compare("reading_rejected", want.reading_rejected, got.reading_rejected);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 req_type_i;
  logic [DIST_BITS-1:0] distance_cm_i;
  logic                 reading_ok_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PHASE_W-1:0]   phase_o;
  logic [HEIGHT_W-1:0]  top_height_o;
  logic [HEIGHT_W-1:0]  base_height_o;
  logic [TOTAL_W-1:0]   height_sum_o;
  logic                 result_valid_o;
  logic                 reading_rejected_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  height_scoreboard sb;

  // When steady is set, neither side inserts gaps, so the block sees long
  // back-to-back stretches of events and an always-ready receiver.
  bit          steady;
  int unsigned hold_cycles = 0;
  height_word_t seen_word;

  three_point_height_sequencer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .distance_cm_i      (distance_cm_i),
    .reading_ok_i       (reading_ok_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .phase_o            (phase_o),
    .top_height_o       (top_height_o),
    .base_height_o      (base_height_o),
    .height_sum_o       (height_sum_o),
    .result_valid_o     (result_valid_o),
    .reading_rejected_o (reading_rejected_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver. After each word it takes, it draws how many cycles it will
  // stall the next one. The stall goes up at the falling edge and stays up,
  // also while no word is present, until the drawn count has run out on a
  // waiting word. Words are sampled at the rising edge.
  always @(negedge clk_i) begin
    out_stall_i <= (hold_cycles != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (out_stall_i) begin
        if (hold_cycles != 0) hold_cycles--;
      end else begin
        seen_word.phase            = phase_o;
        seen_word.top_height       = top_height_o;
        seen_word.base_height      = base_height_o;
        seen_word.height_sum       = height_sum_o;
        seen_word.result_valid     = result_valid_o;
        seen_word.reading_rejected = reading_rejected_o;
        sb.check_word(seen_word);
        hold_cycles = steady ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // Offers one event word after a random gap and returns at the rising edge
  // that takes it. The valid line stays high when the next word follows with
  // no gap, so it is never dropped and raised in the same time step.
  task automatic drive_event(input logic req, input logic [DIST_BITS-1:0] reading,
                             input logic ok);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    distance_cm_i <= reading;
    reading_ok_i  <= ok;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(req, reading, ok);
  endtask

  // A full measurement from idle: the opening press, whose reading is
  // ignored, then the horizontal, top and base captures.
  task automatic run_sequence(input logic [DIST_BITS-1:0] horiz,
                              input logic [DIST_BITS-1:0] top,
                              input logic [DIST_BITS-1:0] base);
    drive_event(REQ_MEASURE, DIST_BITS'($urandom), 1'($urandom));
    drive_event(REQ_MEASURE, horiz, 1'b1);
    drive_event(REQ_MEASURE, top, 1'b1);
    drive_event(REQ_MEASURE, base, 1'b1);
  endtask

  // Stops offering events and waits until every expected word is back.
  // Every event yields a word, so once the queue is empty the block is idle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.backlog() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both window registers while the block is idle. The write valid
  // stays high between the two words.
  task automatic set_window(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    drain();
    for (int i = 0; i < 2; i++) begin
      idx   = (i == 0) ? CFG_MIN_DIST : CFG_MAX_DIST;
      value = (i == 0) ? lo : hi;
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= value;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx, value);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // A reading inside the current window, or any reading when the window is
  // inverted and nothing can pass.
  function automatic logic [DIST_BITS-1:0] window_reading();
    if (sb.win_lo <= sb.win_hi) return DIST_BITS'($urandom_range(sb.win_hi, sb.win_lo));
    return DIST_BITS'($urandom);
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    int unsigned      roll;

    sb            = new();
    steady        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_MEASURE;
    distance_cm_i = '0;
    reading_ok_i  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MIN_DIST;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, on the reset window of 10 to 1200 cm. A reset event
    // while idle, then the opening press with a reading that must be ignored.
    drive_event(REQ_RESET, 16'h1234, 1'b1);
    drive_event(REQ_MEASURE, 16'hFFFF, 1'b0);
    // Horizontal capture: just below and just above the window, a failed
    // sensor read, then the lowest accepted distance.
    drive_event(REQ_MEASURE, 16'd9, 1'b1);
    drive_event(REQ_MEASURE, 16'd1201, 1'b1);
    drive_event(REQ_MEASURE, 16'd500, 1'b0);
    drive_event(REQ_MEASURE, 16'd10, 1'b1);
    // Top at the highest accepted distance; the base first misses the
    // window, then equals the horizontal distance, which gives a zero leg.
    drive_event(REQ_MEASURE, 16'd1200, 1'b1);
    drive_event(REQ_MEASURE, 16'd0, 1'b1);
    drive_event(REQ_MEASURE, 16'd10, 1'b1);
    // A press in complete clears everything back to idle.
    drive_event(REQ_MEASURE, 16'd0, 1'b0);

    // Reset events from the horizontal, top, base and complete phases.
    drive_event(REQ_MEASURE, 16'd77, 1'b1);
    drive_event(REQ_RESET, 16'hFFFF, 1'b0);
    drive_event(REQ_MEASURE, 16'd77, 1'b1);
    drive_event(REQ_MEASURE, 16'd100, 1'b1);
    drive_event(REQ_RESET, 16'd0, 1'b1);
    drive_event(REQ_MEASURE, 16'd77, 1'b1);
    drive_event(REQ_MEASURE, 16'd100, 1'b1);
    drive_event(REQ_MEASURE, 16'd200, 1'b1);
    drive_event(REQ_RESET, 16'd200, 1'b1);
    run_sequence(16'd300, 16'd500, 16'd700);
    drive_event(REQ_RESET, 16'd300, 1'b0);

    // Widest window: a zero horizontal and full-scale legs give the
    // largest heights the block can produce.
    set_window(16'd0, 16'hFFFF);
    run_sequence(16'd0, 16'hFFFF, 16'hFFFF);
    drive_event(REQ_MEASURE, 16'hFFFF, 1'b1);

    // Random part: eight window settings, each for a run of events. Most
    // events are presses with good readings inside the window, so the
    // sequencer keeps walking through whole measurements; the rest are
    // reset events, failed reads and readings with any value at all.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          lo = MIN_DIST_RST;
          hi = MAX_DIST_RST;
        end
        1: begin
          lo = 16'd0;
          hi = 16'hFFFF;
        end
        2, 7: begin
          lo = CFG_W'($urandom_range(0, 2000));
          hi = lo + CFG_W'($urandom_range(0, 3000));
        end
        3: begin
          // Inverted window: every reading is refused.
          hi = CFG_W'($urandom_range(0, 65534));
          lo = CFG_W'($urandom_range(65535, hi + 1));
        end
        4: begin
          lo = 16'd0;
          hi = 16'd0;
        end
        5: begin
          lo = 16'hFFFF;
          hi = 16'hFFFF;
        end
        default: begin
          lo = CFG_W'($urandom_range(40000, 65535));
          hi = 16'hFFFF;
        end
      endcase
      set_window(lo, hi);
      steady = (ph % 3 == 2);
      for (int n = 0; n < 245; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          drive_event(REQ_RESET, DIST_BITS'($urandom), 1'($urandom));
        end else if (roll < 16) begin
          drive_event(REQ_MEASURE, DIST_BITS'($urandom), 1'($urandom));
        end else if (roll < 20) begin
          drive_event(REQ_MEASURE, window_reading(), 1'b0);
        end else begin
          drive_event(REQ_MEASURE, window_reading(), 1'b1);
        end
      end
    end

    // Let the last words come back, then give the height program time to
    // show any stray word before the verdict.
    steady = 1'b0;
    drain();
    repeat (64) @(posedge clk_i);

    $display("Ran %0d events over ten window settings; %0d words checked,", sb.n_events,
             sb.n_words);
    $display("%0d measurements completed and %0d readings refused.", sb.n_complete,
             sb.n_refused);
    if (sb.n_errors == 0 && sb.backlog() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run: every event delayed by the
  // longest gap, the height program and the longest receiver stall.
  initial begin : watchdog
    #10000000;
    $error("run did not finish in time, %0d words still expected", sb.backlog());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
